// ----- design/wamm_pkg.sv -----
package wamm_pkg;

    localparam int CHANNELS      = 8;
    localparam int HISTORY_DEPTH = 64;
    localparam int CH_BITS       = 3;
    localparam int POS_BITS      = 6;
    localparam int CNT_BITS      = 7;
    localparam int MEM_DEPTH     = CHANNELS * HISTORY_DEPTH;
    localparam int ADDR_BITS     = CH_BITS + POS_BITS;
    localparam int ENTRY_BITS    = 64;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic ACTION_PUSH  = 1'b0;
    localparam logic ACTION_QUERY = 1'b1;

    typedef struct packed {
        logic               action;
        logic [2:0]         channel;
        logic [31:0]        event_time;
        logic signed [31:0] sample_value;
        logic [31:0]        window_length;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] average;
        logic               average_valid;
        logic signed [31:0] window_min;
        logic signed [31:0] window_max;
        logic               extremes_valid;
        logic [31:0]        newest_time;
    } out_item_t;

    // Query command handed from the front end to the back end.
    typedef struct packed {
        logic [CH_BITS-1:0]  channel;
        logic [POS_BITS-1:0] newest_pos;
        logic [CNT_BITS-1:0] count;
        logic [31:0]         now;
        logic [31:0]         len;
    } query_cmd_t;

endpackage

// ----- design/window_average_min_max.sv -----
// Per-channel time-weighted window average with min, max and newest time. A push
// is accepted only once every earlier query has finished its walk. A query visits
// up to 64 stored samples, each through the read, step, multiply and wait states,
// adds one more weighted step when the visited samples do not cover the window, and
// ends with a bit-serial divide; its pace is set by the single read port of the
// sample memory and the divider. An empty channel answers straight from the idle
// state, and a zero window or a single sample skip the divide. Up to two queries wait
// in a queue in front of the walk. The sample memory is not cleared; only written
// entries are ever used.
module window_average_min_max (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  wamm_pkg::in_item_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output wamm_pkg::out_item_t  m_data
);
    import wamm_pkg::*;

    logic                  wr_en;
    logic [ADDR_BITS-1:0]  wr_addr, rd_addr;
    logic [ENTRY_BITS-1:0] wr_data, rd_data;
    logic                  fq_valid, fq_ready, bq_valid, bq_ready, back_idle;
    query_cmd_t            fq_data, bq_data;

    wamm_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MEM_DEPTH)) u_ram (
        .aclk (aclk), .wr_en (wr_en), .wr_addr (wr_addr), .wr_data (wr_data),
        .rd_addr (rd_addr), .rd_data (rd_data)
    );

    wamm_front u_front (
        .aclk (aclk), .aresetn (aresetn),
        .s_valid (s_valid), .s_ready (s_ready), .s_data (s_data),
        .mem_wr_en (wr_en), .mem_wr_addr (wr_addr), .mem_wr_data (wr_data),
        .q_valid (fq_valid), .q_ready (fq_ready), .q_data (fq_data),
        .back_idle (back_idle)
    );

    wamm_queue u_queue (
        .aclk (aclk), .aresetn (aresetn),
        .in_valid (fq_valid), .in_ready (fq_ready), .in_data (fq_data),
        .out_valid (bq_valid), .out_ready (bq_ready), .out_data (bq_data)
    );

    wamm_back u_back (
        .aclk (aclk), .aresetn (aresetn),
        .q_valid (bq_valid), .q_ready (bq_ready), .q_data (bq_data),
        .mem_rd_addr (rd_addr), .mem_rd_data (rd_data), .idle (back_idle),
        .m_valid (m_valid), .m_ready (m_ready), .m_data (m_data)
    );

endmodule

// ----- design/wamm_ram.sv -----
module wamm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/wamm_divider.sv -----
module wamm_divider (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [63:0] dividend,
    input  logic [31:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [63:0] quotient
);

    logic [63:0] q_reg, q_next;
    logic [32:0] r_reg, r_next;
    logic [31:0] d_reg, d_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [32:0] shifted;

    always_comb begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {r_reg[31:0], q_reg[63]};
        if (start) begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            cnt_next  = 7'd64;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, d_reg}) begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[62:0], 1'b1};
            end else begin
                r_next = shifted;
                q_next = {q_reg[62:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

// ----- design/wamm_front.sv -----
module wamm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  wamm_pkg::in_item_t  s_data,
    output logic                mem_wr_en,
    output logic [wamm_pkg::ADDR_BITS-1:0]  mem_wr_addr,
    output logic [wamm_pkg::ENTRY_BITS-1:0] mem_wr_data,
    output logic                q_valid,
    input  logic                q_ready,
    output wamm_pkg::query_cmd_t q_data,
    input  logic                back_idle
);
    import wamm_pkg::*;

    logic [POS_BITS-1:0] wpos_reg [CHANNELS];
    logic [CNT_BITS-1:0] fill_reg [CHANNELS];
    logic                is_push;
    logic                ch_ok;
    logic [POS_BITS-1:0] wpos;

    assign ch_ok   = ({1'b0, s_data.channel} < (CH_BITS+1)'(CHANNELS));
    assign is_push = (s_data.action == ACTION_PUSH);
    assign wpos    = wpos_reg[s_data.channel];

    // Pushes wait for an idle back end so a running walk never sees its ring change.
    assign s_ready = is_push ? (back_idle && !q_valid) : q_ready;

    assign mem_wr_en   = s_valid && s_ready && is_push && ch_ok;
    assign mem_wr_addr = {s_data.channel, wpos};
    assign mem_wr_data = {s_data.event_time, s_data.sample_value};

    assign q_valid          = s_valid && !is_push;
    assign q_data.channel   = s_data.channel;
    assign q_data.newest_pos = wpos - POS_BITS'(1);
    assign q_data.count     = ch_ok ? fill_reg[s_data.channel] : '0;
    assign q_data.now       = s_data.event_time;
    assign q_data.len       = s_data.window_length;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHANNELS; i++) begin
                wpos_reg[i] <= '0;
                fill_reg[i] <= '0;
            end
        end else if (mem_wr_en) begin
            wpos_reg[s_data.channel] <= wpos + POS_BITS'(1);
            if (fill_reg[s_data.channel] < CNT_BITS'(HISTORY_DEPTH)) begin
                fill_reg[s_data.channel] <= fill_reg[s_data.channel] + CNT_BITS'(1);
            end
        end
    end

endmodule

// ----- design/wamm_queue.sv -----
module wamm_queue (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  wamm_pkg::query_cmd_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output wamm_pkg::query_cmd_t  out_data
);
    import wamm_pkg::*;

    query_cmd_t  slot_reg [QUEUE_DEPTH];
    logic        rd_reg, rd_next;
    logic        wr_reg, wr_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        push, pop;

    assign in_ready  = (cnt_reg != 2'(QUEUE_DEPTH));
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data  = slot_reg[rd_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        rd_next  = pop  ? ~rd_reg : rd_reg;
        wr_next  = push ? ~wr_reg : wr_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            slot_reg[wr_reg] <= in_data;
        end
    end

endmodule

// ----- design/wamm_back.sv -----
module wamm_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  q_valid,
    output logic                  q_ready,
    input  wamm_pkg::query_cmd_t  q_data,
    output logic [wamm_pkg::ADDR_BITS-1:0]  mem_rd_addr,
    input  logic [wamm_pkg::ENTRY_BITS-1:0] mem_rd_data,
    output logic                  idle,
    output logic                  m_valid,
    input  logic                  m_ready,
    output wamm_pkg::out_item_t   m_data
);
    import wamm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_READ = 3'd1;
    localparam logic [2:0] ST_STEP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DIV  = 3'd4;
    localparam logic [2:0] ST_WAIT = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]          st_reg, st_next;
    query_cmd_t          cmd_reg, cmd_next;
    logic [CNT_BITS-1:0] k_reg, k_next;
    logic [63:0]         acc_reg, acc_next;
    logic [31:0]         prev_reg, prev_next;
    logic signed [31:0]  lastv_reg, lastv_next;
    logic signed [31:0]  lo_reg, lo_next, hi_reg, hi_next;
    logic [31:0]         newest_reg, newest_next;
    logic                ext_on_reg, ext_on_next;
    logic                avg_on_reg, avg_on_next;
    logic                fill_reg, fill_next;
    logic [31:0]         wt_reg, wt_next;
    logic signed [31:0]  mv_reg, mv_next;
    logic [63:0]         prod_reg;
    out_item_t           res_reg, res_next;
    logic                mval_reg, mval_next;

    logic [31:0]         t, a, age;
    logic signed [31:0]  v;
    logic                div_start, div_busy, div_done;
    logic [63:0]         div_in, div_q;
    logic                neg;

    assign t = mem_rd_data[63:32];
    assign v = mem_rd_data[31:0];
    assign age = (t > cmd_reg.now) ? 32'd0 : cmd_reg.now - t;
    assign a = (age < prev_reg) ? prev_reg : age;
    assign mem_rd_addr = {cmd_reg.channel, cmd_reg.newest_pos - k_reg[POS_BITS-1:0]};
    assign neg = acc_reg[63];
    assign div_in = neg ? (64'd0 - acc_reg) : acc_reg;

    wamm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_in),
        .divisor  (cmd_reg.len),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_q)
    );

    assign q_ready = (st_reg == ST_IDLE) && !mval_reg;
    assign idle    = (st_reg == ST_IDLE) && !q_valid;
    assign m_valid = mval_reg;
    assign m_data  = res_reg;

    always_comb begin
        st_next     = st_reg;
        cmd_next    = cmd_reg;
        k_next      = k_reg;
        acc_next    = acc_reg;
        prev_next   = prev_reg;
        lastv_next  = lastv_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        newest_next = newest_reg;
        ext_on_next = ext_on_reg;
        avg_on_next = avg_on_reg;
        fill_next   = fill_reg;
        wt_next     = wt_reg;
        mv_next     = mv_reg;
        res_next    = res_reg;
        mval_next   = mval_reg;
        div_start   = 1'b0;
        if (mval_reg && m_ready) begin
            mval_next = 1'b0;
        end
        case (st_reg)
            ST_IDLE: begin
                if (q_valid && q_ready) begin
                    cmd_next = q_data;
                    k_next   = '0;
                    acc_next = '0;
                    prev_next = '0;
                    if (q_data.count == '0) begin
                        res_next  = '0;
                        mval_next = 1'b1;
                    end else begin
                        st_next = ST_READ;
                    end
                end
            end
            ST_READ: st_next = ST_STEP;
            ST_STEP: begin
                // The average walk and the extremes scan share one read per sample.
                if (k_reg == '0) begin
                    lo_next = v;
                    hi_next = v;
                    newest_next = t;
                    ext_on_next = (t > cmd_reg.now) || (cmd_reg.now - t < cmd_reg.len);
                    avg_on_next = (cmd_reg.len != 0) && (cmd_reg.count != CNT_BITS'(1));
                end else if (ext_on_reg) begin
                    if (t <= cmd_reg.now && cmd_reg.now - t > cmd_reg.len) begin
                        ext_on_next = 1'b0;
                    end else begin
                        if (v < lo_reg) lo_next = v;
                        if (v > hi_reg) hi_next = v;
                    end
                end
                fill_next = 1'b0;
                if (k_reg == '0 || avg_on_reg) begin
                    mv_next = v;
                    if (a < cmd_reg.len) begin
                        wt_next = a - prev_reg;
                        prev_next = a;
                        lastv_next = v;
                    end else begin
                        wt_next = cmd_reg.len - prev_reg;
                        prev_next = cmd_reg.len;
                    end
                    if (k_reg == '0 && !((cmd_reg.len != 0) &&
                                         (cmd_reg.count != CNT_BITS'(1)))) begin
                        wt_next = '0;
                    end
                    st_next = ST_MUL;
                end else begin
                    st_next = ST_MUL;
                    wt_next = '0;
                end
            end
            ST_MUL: begin
                st_next = ST_WAIT;
            end
            ST_WAIT: begin
                acc_next = acc_reg + prod_reg;
                if (fill_reg) begin
                    st_next = ST_DIV;
                end else if (k_reg + CNT_BITS'(1) < cmd_reg.count &&
                             (ext_on_reg || (avg_on_reg && prev_reg < cmd_reg.len))) begin
                    k_next  = k_reg + CNT_BITS'(1);
                    st_next = ST_READ;
                end else if (avg_on_reg && prev_reg < cmd_reg.len) begin
                    fill_next = 1'b1;
                    wt_next   = cmd_reg.len - prev_reg;
                    mv_next   = lastv_reg;
                    prev_next = cmd_reg.len;
                    st_next   = ST_MUL;
                end else begin
                    st_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (!avg_on_reg) begin
                    st_next = ST_OUT;
                end else if (!div_busy && !div_start) begin
                    div_start = 1'b1;
                    st_next   = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!avg_on_reg || div_done) begin
                    res_next.average_valid  = (cmd_reg.len != 0);
                    if (!avg_on_reg) begin
                        res_next.average = (cmd_reg.len != 0) ? lastv_reg : '0;
                    end else begin
                        res_next.average = neg ? 32'(64'd0 - div_q) : div_q[31:0];
                    end
                    res_next.window_min     = lo_reg;
                    res_next.window_max     = hi_reg;
                    res_next.extremes_valid = 1'b1;
                    res_next.newest_time    = newest_reg;
                    mval_next = 1'b1;
                    st_next   = ST_IDLE;
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= ST_IDLE;
            mval_reg <= 1'b0;
        end else begin
            st_reg   <= st_next;
            mval_reg <= mval_next;
        end
        cmd_reg    <= cmd_next;
        k_reg      <= k_next;
        acc_reg    <= acc_next;
        prev_reg   <= prev_next;
        lastv_reg  <= (st_reg == ST_STEP && k_reg == '0) ? v : lastv_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        newest_reg <= newest_next;
        ext_on_reg <= ext_on_next;
        avg_on_reg <= avg_on_next;
        fill_reg   <= fill_next;
        wt_reg     <= wt_next;
        mv_reg     <= mv_next;
        prod_reg   <= 64'($signed({1'b0, wt_reg}) * 33'(mv_reg));
        res_reg    <= res_next;
    end

endmodule

// ----- tb/window_average_min_max_tb.sv -----
module window_average_min_max_tb;
    import wamm_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    window_average_min_max DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    // Shadow copy of the per-channel sample rings.
    logic [31:0]        ring_time [CHANNELS][HISTORY_DEPTH];
    logic signed [31:0] ring_value[CHANNELS][HISTORY_DEPTH];
    int unsigned        ring_wpos [CHANNELS];
    int unsigned        ring_fill [CHANNELS];

    out_item_t pending_stats[$];
    int        error_count;
    int        push_count;
    int        query_count;
    int        result_count;
    bit        stimulus_done;

    function automatic int unsigned slot_back(int unsigned ch, int unsigned k);
        return (ring_wpos[ch] + 2 * HISTORY_DEPTH - 1 - k) % HISTORY_DEPTH;
    endfunction

    // Applies one transaction to the shadow rings; returns 1 with the window
    // statistics when it is a query.
    function automatic bit window_stats(input in_item_t it, output out_item_t r);
        int unsigned       ch;
        int unsigned       n;
        int unsigned       s;
        logic [63:0]       now;
        logic [63:0]       len;
        logic [63:0]       t2;
        logic [63:0]       acc;
        logic [63:0]       prev;
        logic [63:0]       a;
        logic signed [63:0] v;
        logic signed [63:0] last_v;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
        ch  = it.channel;
        now = {32'd0, it.event_time};
        len = {32'd0, it.window_length};
        r   = '0;
        if (it.action == ACTION_PUSH) begin
            s = ring_wpos[ch];
            ring_time[ch][s]  = it.event_time;
            ring_value[ch][s] = it.sample_value;
            ring_wpos[ch] = (s + 1) % HISTORY_DEPTH;
            if (ring_fill[ch] < HISTORY_DEPTH) ring_fill[ch]++;
            return 1'b0;
        end
        n = ring_fill[ch];
        if (n > 0) begin
            s  = slot_back(ch, 0);
            lo = ring_value[ch][s];
            hi = lo;
            r.newest_time    = ring_time[ch][s];
            r.extremes_valid = 1'b1;
            if (ring_time[ch][s] > now || now - ring_time[ch][s] < len) begin
                for (int unsigned k = 1; k < n; k++) begin
                    s  = slot_back(ch, k);
                    t2 = ring_time[ch][s];
                    if (t2 <= now && now - t2 > len) break;
                    if (ring_value[ch][s] < lo) lo = ring_value[ch][s];
                    if (ring_value[ch][s] > hi) hi = ring_value[ch][s];
                end
            end
            r.window_min = lo;
            r.window_max = hi;
        end
        if (len != 0 && n == 1) begin
            r.average       = ring_value[ch][slot_back(ch, 0)];
            r.average_valid = 1'b1;
        end else if (len != 0 && n > 1) begin
            acc    = '0;
            prev   = '0;
            last_v = '0;
            for (int unsigned k = 0; k < n; k++) begin
                s = slot_back(ch, k);
                a = (ring_time[ch][s] > now) ? 64'd0 : now - ring_time[ch][s];
                if (a < prev) a = prev;
                v = ring_value[ch][s];
                if (a < len) begin
                    acc    = acc + (a - prev) * v;
                    prev   = a;
                    last_v = v;
                end else begin
                    acc  = acc + (len - prev) * v;
                    prev = len;
                    break;
                end
            end
            if (prev < len) acc = acc + (len - prev) * last_v;
            if (acc[63]) r.average = 32'(64'd0 - ((64'd0 - acc) / len));
            else         r.average = 32'(acc / len);
            r.average_valid = 1'b1;
        end
        return 1'b1;
    endfunction

    // Directed rows; check_now marks rows whose expected result is typed in.
    typedef struct {
        in_item_t  item;
        bit        check_now;
        out_item_t typed;
    } directed_row_t;

    directed_row_t directed_rows[$];

    function automatic in_item_t make_item(logic act, int unsigned ch, logic [31:0] tm,
                                           logic [31:0] val, logic [31:0] len);
        in_item_t it;
        it.action        = act;
        it.channel       = ch[2:0];
        it.event_time    = tm;
        it.sample_value  = val;
        it.window_length = len;
        return it;
    endfunction

    task automatic add_row(input in_item_t it);
        directed_row_t row;
        row.item      = it;
        row.check_now = 1'b0;
        row.typed     = '0;
        directed_rows.push_back(row);
    endtask

    task automatic add_typed(input in_item_t it, input out_item_t res);
        directed_row_t row;
        row.item      = it;
        row.check_now = 1'b1;
        row.typed     = res;
        directed_rows.push_back(row);
    endtask

    // A query with use_typed set expects the typed result instead of the predictor's.
    task automatic send_item(input in_item_t it, input bit use_typed = 1'b0,
                             input out_item_t typed = '0);
        out_item_t r;
        int        gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (window_stats(it, r)) begin
            pending_stats.push_back(use_typed ? typed : r);
            query_count++;
        end else begin
            push_count++;
        end
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_stats.size() != 0) @(posedge aclk);
    endtask

    // Mostly believable time series; sometimes wild values or reversed time.
    task automatic random_burst(input int unsigned ch);
        logic [31:0] t;
        int          pushes;
        int          queries;
        t       = $urandom_range(0, 3) == 0 ? $urandom() : $urandom_range(0, 100000);
        pushes  = $urandom_range(0, 3) == 0 ? $urandom_range(40, 80) : $urandom_range(1, 12);
        queries = $urandom_range(1, 4);
        for (int i = 0; i < pushes; i++) begin
            case ($urandom_range(0, 9))
                0:       t = $urandom();
                1:       t = t - $urandom_range(0, 500);
                default: t = t + $urandom_range(0, 1000);
            endcase
            send_item(make_item(ACTION_PUSH, ch, t,
                ($urandom_range(0, 4) == 0) ? $urandom() : $urandom_range(0, 32'h00FF_FFFF)
                    - 32'h0080_0000,
                $urandom()));
        end
        for (int i = 0; i < queries; i++) begin
            send_item(make_item(ACTION_QUERY, ch,
                ($urandom_range(0, 5) == 0) ? $urandom() : t + $urandom_range(0, 3000),
                $urandom(),
                ($urandom_range(0, 5) == 0) ? $urandom() : $urandom_range(0, 20000)));
        end
    endtask

    initial begin
        out_item_t empty_res;
        out_item_t r;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        error_count   = 0;
        push_count    = 0;
        query_count   = 0;
        stimulus_done = 1'b0;
        for (int c = 0; c < CHANNELS; c++) begin
            ring_wpos[c] = 0;
            ring_fill[c] = 0;
        end
        empty_res = '0;

        // Empty channel, both window extremes.
        add_typed(make_item(ACTION_QUERY, 0, 32'd1000, 32'd0, 32'd100), empty_res);
        add_typed(make_item(ACTION_QUERY, 7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
                  empty_res);
        // Single sample, then zero window.
        add_row(make_item(ACTION_PUSH, 1, 32'd500, 32'h8000_0000, 32'd0));
        r = '0;
        r.average        = 32'sh8000_0000;
        r.average_valid  = 1'b1;
        r.window_min     = 32'sh8000_0000;
        r.window_max     = 32'sh8000_0000;
        r.extremes_valid = 1'b1;
        r.newest_time    = 32'd500;
        add_typed(make_item(ACTION_QUERY, 1, 32'd600, 32'd0, 32'd1000), r);
        r.average       = '0;
        r.average_valid = 1'b0;
        add_typed(make_item(ACTION_QUERY, 1, 32'd600, 32'd0, 32'd0), r);
        // Several samples: boundary, future and out-of-order times.
        add_row(make_item(ACTION_PUSH, 1, 32'd700, 32'h7FFF_FFFF, 32'd0));
        add_row(make_item(ACTION_PUSH, 1, 32'd650, 32'h0001_0000, 32'd0));
        add_row(make_item(ACTION_PUSH, 1, 32'd2000, 32'hFFFF_0000, 32'd0));
        add_row(make_item(ACTION_QUERY, 1, 32'd1500, 32'd0, 32'd1000));
        add_row(make_item(ACTION_QUERY, 1, 32'd2500, 32'd0, 32'd1800));
        add_row(make_item(ACTION_QUERY, 1, 32'd2500, 32'd0, 32'd2000));
        add_row(make_item(ACTION_QUERY, 1, 32'd2500, 32'd0, 32'd1));
        add_row(make_item(ACTION_QUERY, 1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF));
        add_row(make_item(ACTION_QUERY, 1, 32'd0, 32'd0, 32'd5));
        // Time at the top of its range.
        add_row(make_item(ACTION_PUSH, 2, 32'hFFFF_FFFF, 32'h1234_5678, 32'hFFFF_FFFF));
        add_row(make_item(ACTION_PUSH, 2, 32'hFFFF_FFF0, 32'hEDCB_A988, 32'd0));
        add_row(make_item(ACTION_QUERY, 2, 32'hFFFF_FFFF, 32'd0, 32'd16));

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, directed_rows[i].check_now,
                      directed_rows[i].typed);
        end

        // Wrap a ring so the oldest samples get overwritten.
        for (int i = 0; i < 70; i++)
            send_item(make_item(ACTION_PUSH, 3, 32'(i * 10), $urandom(), 32'd0));
        send_item(make_item(ACTION_QUERY, 3, 32'd700, 32'd0, 32'd300));
        send_item(make_item(ACTION_QUERY, 3, 32'd700, 32'd0, 32'd100000));

        // Hold the sender until the queue is empty.
        drain_results();

        while (push_count + query_count < 480)
            random_burst($urandom_range(0, CHANNELS - 1));

        s_valid <= 1'b0;
        stimulus_done = 1'b1;
    end

    // Result side: random back-pressure, compare against the oldest prediction.
    initial begin
        out_item_t want;
        int        stall;
        m_ready      = 1'b0;
        result_count = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            result_count++;
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result %p", $time, m_data);
                error_count++;
            end else begin
                want = pending_stats.pop_front();
                if (m_data.average !== want.average ||
                    m_data.average_valid !== want.average_valid ||
                    m_data.window_min !== want.window_min ||
                    m_data.window_max !== want.window_max ||
                    m_data.extremes_valid !== want.extremes_valid ||
                    m_data.newest_time !== want.newest_time) begin
                    $display("%0t: mismatch expected %p actual %p", $time, want, m_data);
                    error_count++;
                end
            end
        end
    end

    initial begin
        wait (stimulus_done);
        while (pending_stats.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
        $display("Sent %0d pushes and %0d queries; %0d window results checked.",
                 push_count, query_count, result_count);
        if (error_count == 0 && pending_stats.size() == 0) begin
            $display("window_average_min_max test passed");
        end else begin
            $display("window_average_min_max test failed");
        end
        $finish;
    end

    initial begin
        #60000000;
        $display("window_average_min_max test failed");
        $finish;
    end

endmodule
